// ----- src/prc_pkg.sv -----
// Package for the pixel radial clamp block.
// Field widths, configuration register indexes and defaults; no dependencies.
package prc_pkg;

    localparam int FRAC_BITS_DEF = 4;

    localparam int COORD_W  = 18;   // point and clamped coordinates
    localparam int CENTER_W = 16;   // centre registers
    localparam int RADIUS_W = 18;   // max radius register
    localparam int CFG_W    = 18;   // widest register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 2'd2;

    localparam int QUOT_W = 18;     // scaled offset magnitude

    localparam logic signed [COORD_W+1:0] SAT_MAX = 20'sd131071;
    localparam logic signed [COORD_W+1:0] SAT_MIN = -20'sd131072;

endpackage

// ----- src/prc_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Generic; no package dependency.
module prc_sqrt #(
    parameter int IN_W = 46
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [IN_W-1:0]       radicand,
    output logic [IN_W/2-1:0]     root
);
    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic [RW-1:0]    rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  rad_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic [RW-1:0]    rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  rad_in;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // rem = 4*rem + next pair, trial = 4*root + 1
        assign rem_sh = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[OUT_W-2:0], ge};
                rad_reg[k]  <= {rad_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

// ----- src/prc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Generic; quotient must fit QW bits. No package dependency.
module prc_div #(
    parameter int NW = 41,
    parameter int DW = 24,
    parameter int QW = 18
) (
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  numer,
    input  logic [DW-1:0]  denom,
    output logic [QW-1:0]  quot
);
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            // upper numerator bits are below the divisor when the quotient fits
            assign rem_in = DW'(numer[NW-1:QW]);
            assign low_in = numer[QW-1:0];
            assign den_in = denom;
            assign q_in   = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign sh   = {rem_in, low_in[QW-1]};
        assign diff = sh - {1'b0, den_in};
        assign ge   = (sh >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
                low_reg[k] <= {low_in[QW-2:0], 1'b0};
                den_reg[k] <= den_in;
                q_reg[k]   <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign quot = q_reg[QW-1];

endmodule

// ----- src/pixel_radial_clamp_core.sv -----
// Radial clamp of pixel coordinates onto a disc round a configured centre.
// Uses prc_pkg, prc_sqrt and prc_div.
//
// Usage:
//   Input channel (point_valid / point_stall) carries point_x, point_y, signed
//   fixed point with FRAC_BITS fraction bits. Output channel (result_valid /
//   result_stall) returns clamped_x, clamped_y and inside_res, one result per
//   request, in order.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 center_x, 1 center_y, 2 max_radius); index 3 is ignored. Write only
//   while no request is in flight.
// Pipeline: three front stages (offset, squares, sum), one stage per root bit
//   of the square root, one stage for the inside test and offset*radius
//   product, one stage per quotient bit of the divider, and the saturating
//   output register.
// Throughput: one request per clock unless stalled; stages are plain registers.
// Reset: clears the configuration and all valid bits; the pipe comes up empty.
// Stall: when result_stall holds a valid result the whole pipe freezes and
//   point_stall rises in the same cycle; nothing is lost or repeated.
module pixel_radial_clamp_core #(
    parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 point_valid,
    output logic                                 point_stall,
    input  logic signed [prc_pkg::COORD_W-1:0]   point_x,
    input  logic signed [prc_pkg::COORD_W-1:0]   point_y,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [prc_pkg::COORD_W-1:0]   clamped_x,
    output logic signed [prc_pkg::COORD_W-1:0]   clamped_y,
    output logic                                 inside_res,
    input  logic                                 cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [prc_pkg::CFG_W-1:0]            cfg_data
);
    import prc_pkg::*;

    localparam int SH     = 8 - FRAC_BITS;          // distance gets 8 fraction bits
    localparam int MAG_W  = COORD_W;                // |offset|
    localparam int SQ_W   = 2 * MAG_W + 2 + 2 * SH; // squared distance, even
    localparam int ROOT_W = SQ_W / 2;               // distance d8
    localparam int R8_W   = RADIUS_W + SH;
    localparam int PROD_W = MAG_W + R8_W;
    localparam int NW     = PROD_W + 1;
    localparam int DW     = ROOT_W + 1;
    localparam int LAT    = 5 + ROOT_W + QUOT_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [MAG_W-1:0]          ax;
        logic [MAG_W-1:0]          ay;
        logic                      negx;
        logic                      negy;
    } front_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      negx;
        logic                      negy;
        logic                      in_circ;
        logic                      zero;
    } back_t;

    // configuration
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [RADIUS_W-1:0] max_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            max_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[CENTER_W-1:0];
                REG_MAX_RADIUS: max_radius_reg <= cfg_data[RADIUS_W-1:0];
                default:        ;
            endcase
        end
    end

    // global advance: the pipe moves unless a finished result is held
    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv         = !vld_reg[LAT-1] || !result_stall;
    assign point_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], point_valid};
    end

    // stage A: offsets from centre, magnitudes and signs
    logic signed [COORD_W:0] dx, dy;
    front_t a_reg;

    assign dx = {point_x[COORD_W-1], point_x} - $signed({3'b000, center_x_reg});
    assign dy = {point_y[COORD_W-1], point_y} - $signed({3'b000, center_y_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg.px   <= point_x;
            a_reg.py   <= point_y;
            a_reg.negx <= dx[COORD_W];
            a_reg.negy <= dy[COORD_W];
            a_reg.ax   <= dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
            a_reg.ay   <= dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
        end
    end

    // stage B: squares
    logic [2*MAG_W-1:0] sqx_reg, sqy_reg;
    front_t b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= a_reg.ax * a_reg.ax;
            sqy_reg <= a_reg.ay * a_reg.ay;
            b_reg   <= a_reg;
        end
    end

    // stage C: sum, scaled so the root carries 8 fraction bits
    logic [SQ_W-1:0] sq_reg;
    front_t c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= SQ_W'({1'b0, sqx_reg} + {1'b0, sqy_reg}) << (2 * SH);
            c_reg  <= b_reg;
        end
    end

    // square root, ROOT_W stages
    logic [ROOT_W-1:0] d8;
    front_t sd1_reg [ROOT_W];

    prc_sqrt #(
        .IN_W (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (sq_reg),
        .root     (d8)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd1_reg[0] <= c_reg;
            for (int i = 1; i < ROOT_W; i++)
                sd1_reg[i] <= sd1_reg[i-1];
        end
    end

    // stage E: inside test, numerators 2*|d|*r8 + d8 and divisor 2*d8
    logic [R8_W-1:0] r8;
    logic [NW-1:0]   numx_reg, numy_reg;
    logic [DW-1:0]   den_reg;
    back_t           e_reg;
    front_t          sf;

    assign r8 = R8_W'(max_radius_reg) << SH;
    assign sf = sd1_reg[ROOT_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx_reg      <= {PROD_W'(sf.ax) * PROD_W'(r8), 1'b0} + NW'(d8);
            numy_reg      <= {PROD_W'(sf.ay) * PROD_W'(r8), 1'b0} + NW'(d8);
            den_reg       <= {d8, 1'b0};
            e_reg.px      <= sf.px;
            e_reg.py      <= sf.py;
            e_reg.negx    <= sf.negx;
            e_reg.negy    <= sf.negy;
            e_reg.in_circ <= ({{SH{1'b0}}, d8} < {{(ROOT_W - R8_W + SH){1'b0}}, r8});
            e_reg.zero    <= (d8 == '0);
        end
    end

    // dividers, QUOT_W stages each
    logic [QUOT_W-1:0] qx, qy;
    back_t sd2_reg [QUOT_W];

    prc_div #(
        .NW (NW),
        .DW (DW),
        .QW (QUOT_W)
    ) u_div_x (
        .clk   (clk),
        .en    (adv),
        .numer (numx_reg),
        .denom (den_reg),
        .quot  (qx)
    );

    prc_div #(
        .NW (NW),
        .DW (DW),
        .QW (QUOT_W)
    ) u_div_y (
        .clk   (clk),
        .en    (adv),
        .numer (numy_reg),
        .denom (den_reg),
        .quot  (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd2_reg[0] <= e_reg;
            for (int i = 1; i < QUOT_W; i++)
                sd2_reg[i] <= sd2_reg[i-1];
        end
    end

    // output: point inside, centre at zero, else centre +/- scaled offset, clipped
    back_t sb;
    logic signed [COORD_W+1:0] sumx, sumy;
    logic signed [COORD_W-1:0] ox_next, oy_next, satx, saty;
    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic                      in_reg;

    assign sb = sd2_reg[QUOT_W-1];

    assign sumx = sb.negx ? $signed({4'b0, center_x_reg}) - $signed({2'b0, qx})
                          : $signed({4'b0, center_x_reg}) + $signed({2'b0, qx});
    assign sumy = sb.negy ? $signed({4'b0, center_y_reg}) - $signed({2'b0, qy})
                          : $signed({4'b0, center_y_reg}) + $signed({2'b0, qy});

    always_comb
    begin
        satx = COORD_W'(sumx);
        saty = COORD_W'(sumy);
        if (sumx > SAT_MAX)      satx = COORD_W'(SAT_MAX);
        else if (sumx < SAT_MIN) satx = COORD_W'(SAT_MIN);
        if (sumy > SAT_MAX)      saty = COORD_W'(SAT_MAX);
        else if (sumy < SAT_MIN) saty = COORD_W'(SAT_MIN);

        priority if (sb.in_circ)
        begin
            ox_next = sb.px;
            oy_next = sb.py;
        end
        else if (sb.zero)
        begin
            ox_next = $signed({2'b00, center_x_reg});
            oy_next = $signed({2'b00, center_y_reg});
        end
        else
        begin
            ox_next = satx;
            oy_next = saty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            in_reg <= sb.in_circ;
        end
    end

    assign result_valid = vld_reg[LAT-1];
    assign clamped_x    = ox_reg;
    assign clamped_y    = oy_reg;
    assign inside_res   = in_reg;

endmodule

// ----- src/prc_checker.sv -----
// Port-level checks for pixel_radial_clamp_core, attached by bind.
// Depends on prc_pkg.
module prc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               point_valid,
    input logic                               point_stall,
    input logic signed [prc_pkg::COORD_W-1:0] point_x,
    input logic signed [prc_pkg::COORD_W-1:0] point_y,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic signed [prc_pkg::COORD_W-1:0] clamped_x,
    input logic signed [prc_pkg::COORD_W-1:0] clamped_y,
    input logic                               inside_res,
    input logic                               cfg_we,
    input logic [prc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [prc_pkg::CFG_W-1:0]          cfg_data
);
    import prc_pkg::*;

    // input is held back only by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (result_valid && result_stall))
        else $error("point_stall without a held result");

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(clamped_x)
            && $stable(clamped_y) && $stable(inside_res)))
        else $error("held result changed");

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result after reset");

    // no result from an empty pipe after reset when no request was given
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!rst_n, 2) && !$past(point_valid)) |-> !result_valid)
        else $error("result from nothing");

endmodule

bind pixel_radial_clamp_core prc_checker u_prc_checker (.*);
